### hdl/proj_pkg.sv
// Shared constants and types for the world-to-screen projection pipeline.
// Depends on nothing; proj_dot, proj_div and the top level refer to it by scoped names.
package proj_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_W         = 64;
	localparam int SIZE_W        = 14;
	localparam int QB            = 41;  // quotient bits: term magnitude capped at 2^40
	localparam int IDX_W         = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_COEF_X_LO = 3'd0,
		REG_COEF_X_HI = 3'd1,
		REG_COEF_Y_LO = 3'd2,
		REG_COEF_Y_HI = 3'd3,
		REG_COEF_W_LO = 3'd4,
		REG_COEF_W_HI = 3'd5,
		REG_SCREEN_W  = 3'd6,
		REG_SCREEN_H  = 3'd7
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] SCREEN_W_RST = 14'd1920;
	localparam logic [SIZE_W-1:0] SCREEN_H_RST = 14'd1080;

	// sideband that rides next to the divider pipeline
	typedef struct packed {
		logic vis;
		logic neg_x;
		logic neg_y;
	} side_t;

endpackage

### hdl/proj_if.sv
// Valid/ready channel interfaces for world points in and screen points out.
// Depends on nothing but the payload widths of the block.
interface proj_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] world_x;
	logic signed [31:0] world_y;
	logic signed [31:0] world_z;
	modport source(output valid, world_x, world_y, world_z, input ready);
	modport sink(input valid, world_x, world_y, world_z, output ready);
endinterface

interface proj_px_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	modport source(output valid, visible, screen_x, screen_y, input ready);
	modport sink(input valid, visible, screen_x, screen_y, output ready);
endinterface

### hdl/proj_dot.sv
// Two-stage clip computation: nine weight-by-coordinate products, then
// floor shift and column sums. Uses proj_pkg for register widths.
module proj_dot #(
	parameter int FRAC_BITS = proj_pkg::FRAC_BITS_DEF,
	localparam int CLIP_W = 66 - FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [31:0]       world_x,
	input  logic signed [31:0]       world_y,
	input  logic signed [31:0]       world_z,
	input  logic [proj_pkg::CFG_W-1:0] coef [6],
	output logic signed [CLIP_W-1:0] clip_x_s2,
	output logic signed [CLIP_W-1:0] clip_y_s2,
	output logic signed [CLIP_W-1:0] clip_w_s2
);

	logic signed [31:0] wt [9];
	logic signed [31:0] pt [3];
	logic signed [31:0] tr [3];
	logic signed [63:0] prod_s1 [9];
	logic signed [63:0] shf [9];
	logic signed [CLIP_W-1:0] sum_c [3];

	// pick the weights out of the packed register pairs
	always_comb begin
		pt[0] = world_x;
		pt[1] = world_y;
		pt[2] = world_z;
		for (int c = 0; c < 3; c++) begin
			wt[c*3]   = $signed(coef[2*c][31:0]);
			wt[c*3+1] = $signed(coef[2*c][63:32]);
			wt[c*3+2] = $signed(coef[2*c+1][31:0]);
			tr[c]     = $signed(coef[2*c+1][63:32]);
		end
	end

	// stage 1: register the exact products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++)
				prod_s1[i] <= wt[i] * pt[i % 3];
		end
	end

	// floor shift and sum each column with its translation
	always_comb begin
		for (int i = 0; i < 9; i++)
			shf[i] = prod_s1[i] >>> FRAC_BITS;
		for (int c = 0; c < 3; c++)
			sum_c[c] = shf[c*3][CLIP_W-1:0] + shf[c*3+1][CLIP_W-1:0]
				+ shf[c*3+2][CLIP_W-1:0] + CLIP_W'(tr[c]);
	end

	// stage 2: clip values
	always_ff @(posedge clk) begin
		if (en) begin
			clip_x_s2 <= sum_c[0];
			clip_y_s2 <= sum_c[1];
			clip_w_s2 <= sum_c[2];
		end
	end

endmodule

### hdl/proj_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flag
// when the quotient reaches 2^QB. Uses proj_pkg for the quotient width.
module proj_div #(
	parameter int FRAC_BITS = proj_pkg::FRAC_BITS_DEF,
	localparam int CLIP_W = 66 - FRAC_BITS,
	localparam int DW = CLIP_W - 1,
	localparam int NW = CLIP_W + proj_pkg::SIZE_W + FRAC_BITS - 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [NW-1:0]           num,
	input  logic [DW-1:0]           den,
	output logic [proj_pkg::QB-1:0] quot,
	output logic                    ovf
);

	localparam int QB = proj_pkg::QB;

	logic [DW-1:0] rem_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic [QB-1:0] low_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic          ovf_s [QB+1];
	logic [DW:0]   trial [QB];
	logic          ge    [QB];
	logic [DW-1:0] hi_top;

	// first stage: overflow test on the top bits and seed of the remainder
	assign hi_top = DW'(num[NW-1:QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi_top >= den;
			rem_s[0] <= (hi_top >= den) ? '0 : hi_top;
			den_s[0] <= den;
			low_s[0] <= num[QB-1:0];
			q_s[0]   <= '0;
		end
	end

	// shift in the next numerator bit and try a subtract
	always_comb begin
		for (int k = 0; k < QB; k++) begin
			trial[k] = {rem_s[k], low_s[k][QB-1]};
			ge[k]    = trial[k] >= {1'b0, den_s[k]};
		end
	end

	// advance every step by one stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QB; k++) begin
				rem_s[k+1] <= ge[k] ? DW'(trial[k] - {1'b0, den_s[k]}) : trial[k][DW-1:0];
				den_s[k+1] <= den_s[k];
				low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
				q_s[k+1]   <= {q_s[k][QB-2:0], ge[k]};
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	assign quot = q_s[QB];
	assign ovf  = ovf_s[QB];

endmodule

### hdl/world_to_screen_projection.sv
// Top level: config registers, depth test, axis scaling, dividers, viewport map.
// Depends on proj_pkg, proj_if, proj_dot and proj_div.
//
//   channel  | dir | handshake     | word
//   points   | in  | valid/ready   | world_x, world_y, world_z
//   pixels   | out | valid/ready   | visible, screen_x, screen_y
//   cfg      | in  | cfg_wr_en     | cfg_idx, cfg_data
//
// One point per cycle while the output is not held. The dot products, the axis
// scaling, the divider (one quotient bit per stage) and the viewport map with
// saturation are registered in that order. Reset clears the valid bits and loads
// the register defaults. A stalled output word freezes the whole pipeline.
module world_to_screen_projection #(
	parameter int FRAC_BITS = proj_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	proj_pt_if.sink                       points,
	proj_px_if.source                     pixels,
	input  logic                          cfg_wr_en,
	input  logic [proj_pkg::IDX_W-1:0]    cfg_idx,
	input  logic [proj_pkg::CFG_W-1:0]    cfg_data
);

	localparam int SIZE_W  = proj_pkg::SIZE_W;
	localparam int QB      = proj_pkg::QB;
	localparam int CLIP_W  = 66 - FRAC_BITS;
	localparam int DW      = CLIP_W - 1;
	localparam int HALF    = CLIP_W / 2;
	localparam int PW      = CLIP_W + SIZE_W;
	localparam int NW      = PW + FRAC_BITS - 1;
	localparam int DIV_LAT = QB + 1;
	localparam int LAT     = DIV_LAT + 4;
	localparam int SW      = QB + 3;
	localparam int NEAR    = (1 << FRAC_BITS) / 1000;
	localparam logic signed [CLIP_W-1:0] NEAR_V = CLIP_W'(NEAR);
	localparam logic [QB-1:0]            CAP    = QB'(1) << (QB - 1);
	localparam logic signed [SW-1:0]     HALF_V = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0]     MAX_V  = SW'(32'sh7fffffff);
	localparam logic signed [SW-1:0]     MIN_V  = -SW'(33'sh080000000);

	logic [proj_pkg::CFG_W-1:0] coef_q [6];
	logic [SIZE_W-1:0]          scr_w_q, scr_h_q;
	logic                       en;
	logic [LAT-1:0]             v_q;

	logic signed [CLIP_W-1:0] clip_x_s2, clip_y_s2, clip_w_s2;
	logic [CLIP_W-1:0]        mag_x, mag_y;
	logic [HALF+SIZE_W-1:0]   pp_xl_s3, pp_yl_s3;
	logic [CLIP_W-HALF+SIZE_W-1:0] pp_xh_s3, pp_yh_s3;
	logic [DW-1:0]            den_s3;
	proj_pkg::side_t          side_s3;
	proj_pkg::side_t          side_q [DIV_LAT];
	logic [NW-1:0]            num_x, num_y;
	logic [QB-1:0]            quot_x, quot_y;
	logic                     ovf_x, ovf_y;
	logic [QB-1:0]            tcap_x, tcap_y;
	logic signed [SW-1:0]     term_x, term_y, base_x, base_y, sx, sy;
	logic                     vis_q;
	logic signed [31:0]       sx_q, sy_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				coef_q[i] <= '0;
			scr_w_q <= proj_pkg::SCREEN_W_RST;
			scr_h_q <= proj_pkg::SCREEN_H_RST;
		end else if (cfg_wr_en) begin
			case (proj_pkg::reg_idx_t'(cfg_idx))
				proj_pkg::REG_SCREEN_W: scr_w_q <= cfg_data[SIZE_W-1:0];
				proj_pkg::REG_SCREEN_H: scr_h_q <= cfg_data[SIZE_W-1:0];
				default:                coef_q[cfg_idx] <= cfg_data;
			endcase
		end
	end

	// advance unless the output word is held
	assign en           = !v_q[LAT-1] || pixels.ready;
	assign points.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[LAT-2:0], points.valid};
	end

	proj_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
		.clk      (clk),
		.en       (en),
		.world_x  (points.world_x),
		.world_y  (points.world_y),
		.world_z  (points.world_z),
		.coef     (coef_q),
		.clip_x_s2(clip_x_s2),
		.clip_y_s2(clip_y_s2),
		.clip_w_s2(clip_w_s2)
	);

	// stage 3: depth test, magnitudes times viewport size in two halves
	assign mag_x = clip_x_s2[CLIP_W-1] ? -clip_x_s2 : clip_x_s2;
	assign mag_y = clip_y_s2[CLIP_W-1] ? -clip_y_s2 : clip_y_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_xl_s3      <= mag_x[HALF-1:0] * scr_w_q;
			pp_xh_s3      <= mag_x[CLIP_W-1:HALF] * scr_w_q;
			pp_yl_s3      <= mag_y[HALF-1:0] * scr_h_q;
			pp_yh_s3      <= mag_y[CLIP_W-1:HALF] * scr_h_q;
			den_s3        <= clip_w_s2[DW-1:0];
			side_s3.vis   <= clip_w_s2 > NEAR_V;
			side_s3.neg_x <= clip_x_s2[CLIP_W-1];
			side_s3.neg_y <= clip_y_s2[CLIP_W-1];
		end
	end

	// join the halves and scale by half a pixel unit
	assign num_x = NW'((PW'(pp_xh_s3) << HALF) + PW'(pp_xl_s3)) << (FRAC_BITS - 1);
	assign num_y = NW'((PW'(pp_yh_s3) << HALF) + PW'(pp_yl_s3)) << (FRAC_BITS - 1);

	proj_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .en(en), .num(num_x), .den(den_s3), .quot(quot_x), .ovf(ovf_x)
	);

	proj_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .en(en), .num(num_y), .den(den_s3), .quot(quot_y), .ovf(ovf_y)
	);

	// carry the depth flag and signs next to the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < DIV_LAT; i++)
				side_q[i] <= side_q[i-1];
		end
	end

	// cap the terms, restore signs, map onto the viewport
	always_comb begin
		tcap_x = (ovf_x || quot_x > CAP) ? CAP : quot_x;
		tcap_y = (ovf_y || quot_y > CAP) ? CAP : quot_y;
		term_x = side_q[DIV_LAT-1].neg_x ? -SW'(tcap_x) : SW'(tcap_x);
		term_y = side_q[DIV_LAT-1].neg_y ? -SW'(tcap_y) : SW'(tcap_y);
		base_x = SW'(scr_w_q) << (FRAC_BITS - 1);
		base_y = SW'(scr_h_q) << (FRAC_BITS - 1);
		sx     = base_x + term_x + HALF_V;
		sy     = base_y - (term_y + HALF_V);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			vis_q <= side_q[DIV_LAT-1].vis;
			if (!side_q[DIV_LAT-1].vis) begin
				sx_q <= '0;
				sy_q <= '0;
			end else begin
				sx_q <= (sx > MAX_V) ? 32'sh7fffffff : (sx < MIN_V) ? 32'sh80000000 : sx[31:0];
				sy_q <= (sy > MAX_V) ? 32'sh7fffffff : (sy < MIN_V) ? 32'sh80000000 : sy[31:0];
			end
		end
	end

	assign pixels.valid    = v_q[LAT-1];
	assign pixels.visible  = vis_q;
	assign pixels.screen_x = sx_q;
	assign pixels.screen_y = sy_q;

	// a held output word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && !pixels.ready |=> pixels.valid)
		else $error("output word dropped while stalled");

	// an invisible point reports the origin
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && !pixels.visible |-> pixels.screen_x == 0 && pixels.screen_y == 0)
		else $error("invisible point with nonzero coordinates");

	// a stall freezes the valid line
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_q))
		else $error("pipeline moved during a stall");

	// an accepted point enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		points.valid && points.ready |=> v_q[0])
		else $error("accepted point lost at entry");

endmodule

### verif/proj_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the world-to-screen projection: tracks the register file,
// predicts each screen word and compares it with the output channel.
// Depends on proj_pkg and the channel interfaces in proj_if.
module proj_checker #(
	parameter int FRAC_BITS = proj_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	proj_pt_if                         points,
	proj_px_if                         pixels,
	input  logic                       cfg_wr_en,
	input  logic [proj_pkg::IDX_W-1:0] cfg_idx,
	input  logic [proj_pkg::CFG_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);

	typedef struct packed {
		logic               vis;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} pixel_t;

	localparam logic signed [63:0] NEAR_DEPTH = (64'sd1 <<< FRAC_BITS) / 1000;
	localparam logic [127:0]       TERM_CAP   = 128'd1 << 40;

	logic [proj_pkg::CFG_W-1:0]  coef [6];
	logic [proj_pkg::SIZE_W-1:0] scr_w, scr_h;
	pixel_t                      projected_q [$];

	assign pending = projected_q.size();

	// one column of the view matrix against the point, floored per product
	function automatic logic signed [63:0] column_dot(logic [63:0] lo, logic [63:0] hi,
			logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [63:0] wa, wb, wc, tr, ea, eb, ec;
		wa = $signed(lo[31:0]);
		wb = $signed(lo[63:32]);
		wc = $signed(hi[31:0]);
		tr = $signed(hi[63:32]);
		ea = px;
		eb = py;
		ec = pz;
		return ((wa * ea) >>> FRAC_BITS) + ((wb * eb) >>> FRAC_BITS)
			+ ((wc * ec) >>> FRAC_BITS) + tr;
	endfunction

	// |clip| * size * 2^F / (2 * depth), truncated, capped, signed like clip
	function automatic logic signed [63:0] axis_offset(logic signed [63:0] clip,
			logic [proj_pkg::SIZE_W-1:0] size, logic signed [63:0] depth);
		logic [127:0] mag, quo;
		mag = (clip < 0) ? 128'(-clip) : 128'(clip);
		quo = ((mag * 128'(size)) << FRAC_BITS) / (128'(depth) << 1);
		if (quo > TERM_CAP)
			quo = TERM_CAP;
		return (clip < 0) ? -$signed(64'(quo)) : $signed(64'(quo));
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic pixel_t project_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		logic signed [63:0] cx, cy, cw, half;
		pixel_t r;
		cx = column_dot(coef[proj_pkg::REG_COEF_X_LO], coef[proj_pkg::REG_COEF_X_HI],
			px, py, pz);
		cy = column_dot(coef[proj_pkg::REG_COEF_Y_LO], coef[proj_pkg::REG_COEF_Y_HI],
			px, py, pz);
		cw = column_dot(coef[proj_pkg::REG_COEF_W_LO], coef[proj_pkg::REG_COEF_W_HI],
			px, py, pz);
		r = '0;
		if (cw > NEAR_DEPTH) begin
			half = 64'sd1 <<< (FRAC_BITS - 1);
			r.vis = 1'b1;
			r.sx = clamp32($signed(64'(scr_w) << (FRAC_BITS - 1))
				+ axis_offset(cx, scr_w, cw) + half);
			r.sy = clamp32($signed(64'(scr_h) << (FRAC_BITS - 1))
				- (axis_offset(cy, scr_h, cw) + half));
		end
		return r;
	endfunction

	// mirror register writes, predict on input words, compare output words
	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				coef[i] = '0;
			scr_w = proj_pkg::SCREEN_W_RST;
			scr_h = proj_pkg::SCREEN_H_RST;
			errors = 0;
			projected_q.delete();
		end else begin
			if (pixels.valid && pixels.ready) begin
				if (projected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word vis=%0b x=%0h y=%0h", $time,
						pixels.visible, pixels.screen_x, pixels.screen_y);
				end else begin
					want = projected_q.pop_front();
					if (pixels.visible !== want.vis) begin
						errors++;
						$display("%0t: visible expected %0b actual %0b", $time,
							want.vis, pixels.visible);
					end
					if (pixels.screen_x !== want.sx) begin
						errors++;
						$display("%0t: screen_x expected %08h actual %08h", $time,
							want.sx, pixels.screen_x);
					end
					if (pixels.screen_y !== want.sy) begin
						errors++;
						$display("%0t: screen_y expected %08h actual %08h", $time,
							want.sy, pixels.screen_y);
					end
				end
			end
			if (points.valid && points.ready)
				projected_q.push_back(project_point(points.world_x, points.world_y,
					points.world_z));
			if (cfg_wr_en) begin
				case (proj_pkg::reg_idx_t'(cfg_idx))
					proj_pkg::REG_SCREEN_W: scr_w = cfg_data[proj_pkg::SIZE_W-1:0];
					proj_pkg::REG_SCREEN_H: scr_h = cfg_data[proj_pkg::SIZE_W-1:0];
					default:                coef[cfg_idx] = cfg_data;
				endcase
			end
		end
	end

endmodule

### verif/tb_world_to_screen_projection.sv
`timescale 1ns / 1ps
// Testbench top for world_to_screen_projection: clock, reset, register setup,
// point stimulus, output back-pressure and verdict. Depends on proj_pkg,
// proj_if and proj_checker.
module tb_world_to_screen_projection;

	localparam logic [31:0] ONE = 32'h0001_0000;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [proj_pkg::IDX_W-1:0] cfg_idx;
	logic [proj_pkg::CFG_W-1:0] cfg_data;
	int errors, pending;
	int idle_cycles;
	bit hold_req;
	bit no_stall;

	proj_pt_if points();
	proj_px_if pixels();

	world_to_screen_projection u_dut (
		.clk(clk), .arst_n(arst_n), .points(points), .pixels(pixels),
		.cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	proj_checker u_checker (
		.clk(clk), .arst_n(arst_n), .points(points), .pixels(pixels),
		.cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 3) != 0)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// stall the output side at random; honor a long hold-off once on request
	initial begin
		int stall;
		bit held;
		pixels.ready <= 1'b0;
		stall = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				pixels.ready <= 1'b0;
				repeat (300) @(posedge clk);
				held = 1'b1;
				pixels.ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				pixels.ready <= 1'b0;
			end else begin
				pixels.ready <= 1'b1;
				if (!no_stall)
					stall = gap_len();
			end
		end
	end

	// abort when nothing moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((points.valid && points.ready) || (pixels.valid && pixels.ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 5000) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic write_reg(proj_pkg::reg_idx_t idx, logic [proj_pkg::CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic load_matrix(logic [63:0] xl, logic [63:0] xh, logic [63:0] yl,
			logic [63:0] yh, logic [63:0] wl, logic [63:0] wh, int w, int h);
		write_reg(proj_pkg::REG_COEF_X_LO, xl);
		write_reg(proj_pkg::REG_COEF_X_HI, xh);
		write_reg(proj_pkg::REG_COEF_Y_LO, yl);
		write_reg(proj_pkg::REG_COEF_Y_HI, yh);
		write_reg(proj_pkg::REG_COEF_W_LO, wl);
		write_reg(proj_pkg::REG_COEF_W_HI, wh);
		write_reg(proj_pkg::REG_SCREEN_W, 64'(w));
		write_reg(proj_pkg::REG_SCREEN_H, 64'(h));
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		gap = no_stall ? 0 : gap_len();
		if (gap > 0) begin
			points.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		points.valid <= 1'b1;
		points.world_x <= x;
		points.world_y <= y;
		points.world_z <= z;
		do @(posedge clk); while (!points.ready);
	endtask

	// hold until every word has drained, then let the pipeline settle
	task automatic drain();
		points.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0, 1:    return $urandom();
			2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		if ($urandom_range(0, 7) == 0)
			return $urandom();
		return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
	endfunction

	function automatic logic [63:0] rand_pair();
		return {rand_weight(), rand_weight()};
	endfunction

	initial begin
		logic [31:0] wt;
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		points.valid <= 1'b0;
		points.world_x <= '0;
		points.world_y <= '0;
		points.world_z <= '0;
		hold_req = 1'b0;
		no_stall = 1'b0;
		repeat (11) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// reset matrix is all zero: every point lies behind the near plane
		send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_point(ONE, ONE, ONE);
		drain();

		// plain perspective: depth equals z, around the near limit
		load_matrix({32'h0, ONE}, 64'h0, {ONE, 32'h0}, 64'h0, 64'h0, {32'h0, ONE}, 1920, 1080);
		send_point(ONE, ONE, ONE);
		send_point(32'hffff0000, 32'hffff8000, 2 * ONE);
		send_point(ONE, ONE, 32'd65);
		send_point(ONE, ONE, 32'd66);
		send_point(32'd0, 32'd0, 32'd0);
		send_point(32'h7fffffff, 32'h80000000, 32'd66);
		send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h0, 32'h0, 32'h80000000);
		send_point(32'hffffffff, 32'h1, 32'd100);
		drain();

		// extreme weights and an 8192 by 8192 viewport
		load_matrix(64'h7fffffff_80000000, 64'h80000000_7fffffff, 64'h80000000_80000000,
			64'h7fffffff_7fffffff, 64'h7fffffff_7fffffff, 64'h7fffffff_7fffffff, 8192, 8192);
		send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_point(32'h80000000, 32'h80000000, 32'h80000000);
		send_point(ONE, 32'h0, 32'h0);
		send_point(32'h1, 32'h1, 32'h1);
		drain();

		// one pixel, then collapsed and oversized axes
		load_matrix({32'h0, ONE}, 64'h0, {ONE, 32'h0}, 64'h0, 64'h0, {32'h0, ONE}, 1, 1);
		send_point(ONE, 32'hffff0000, ONE);
		send_point(32'h7fffffff, 32'h80000000, ONE);
		drain();
		write_reg(proj_pkg::REG_SCREEN_W, 64'd0);
		write_reg(proj_pkg::REG_SCREEN_H, 64'h3fff);
		send_point(ONE, 32'hffff0000, ONE);
		send_point(32'h80000000, 32'h7fffffff, 32'd200);
		drain();

		// random matrices; depth leans positive so most points project
		for (int ph = 0; ph < 10; ph++) begin
			wt = 32'($urandom_range(0, 32'h0008_0000)) + 32'h0000_1000;
			load_matrix(rand_pair(), rand_pair(), rand_pair(), rand_pair(),
				{rand_weight(), rand_weight()}, {wt, rand_weight()},
				(ph == 0) ? 8192 : (ph == 1) ? 1 : $urandom_range(1, 8192),
				(ph == 0) ? 1 : (ph == 1) ? 8192 : $urandom_range(1, 8192));
			no_stall = (ph == 4);
			for (int i = 0; i < 120; i++) begin
				if (ph == 3 && i == 10)
					hold_req = 1'b1;
				if (ph == 6 && i == 60) begin
					points.valid <= 1'b0;
					while (pending != 0) @(posedge clk);
				end
				send_point(rand_coord(), rand_coord(), rand_coord());
			end
			drain();
		end
		no_stall = 1'b0;

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
